// ----- rtl/core/rlit_pkg.sv -----
// Shared types and constants for the register lifetime interval table.
// No dependencies; every other file in the project but rlit_ram uses this package.
`timescale 1ns / 1ps

package rlit_pkg;

  localparam int NUM_REGS      = 256;
  localparam int MAX_INTERVALS = 8;
  localparam int POS_WIDTH     = 32;
  localparam int REG_W         = $clog2(NUM_REGS);
  localparam int SLOT_W        = $clog2(MAX_INTERVALS);
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int RC_W          = 9;
  localparam int IV_DEPTH      = NUM_REGS * MAX_INTERVALS;

  typedef logic [POS_WIDTH-1:0] pos_t;

  typedef enum logic [1:0] {
    OP_MARK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_SPAN   = 2'd2,
    OP_ACTIVE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOB  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    pos_t start;
    pos_t stop;
  } iv_t;

  typedef struct packed {
    pos_t             start;
    pos_t             stop;
    logic [CNT_W-1:0] count;
  } rec_t;

  localparam int IV_W  = $bits(iv_t);
  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_LOAD,
    S_FIND,
    S_ABSORB,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic rec_load;
    logic load_step;
    logic find;
    logic absorb;
    logic wr_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic oob;
    op_t  op;
    logic load_done;
    logic refuse;
    logic absorb_more;
    logic write_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/core/rlit_ifs.sv -----
// Channel interfaces: input item, result word and configuration write.
// Depends on rlit_pkg.
`timescale 1ns / 1ps

interface rlit_item_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [rlit_pkg::REG_W-1:0]   reg_index;
  rlit_pkg::pos_t               position;
  rlit_pkg::pos_t               interval_stop;
  modport source (output valid, opcode, reg_index, position, interval_stop, input ready);
  modport sink (input valid, opcode, reg_index, position, interval_stop, output ready);
endinterface

interface rlit_result_if;
  logic           valid;
  logic           ready;
  logic [1:0]     status;
  rlit_pkg::pos_t out_start;
  rlit_pkg::pos_t out_stop;
  modport source (output valid, status, out_start, out_stop, input ready);
  modport sink (input valid, status, out_start, out_stop, output ready);
endinterface

interface rlit_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rlit_pkg::RC_W-1:0] register_count;
  modport source (output valid, register_count, input ready);
  modport sink (input valid, register_count, output ready);
endinterface

// ----- rtl/core/rlit_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module rlit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/rlit_ctrl.sv -----
// Controller state machine: sequences record read, list load, search,
// absorb, write back and result hand-off. Depends on rlit_pkg.
`timescale 1ns / 1ps

module rlit_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  rlit_pkg::sts_t sts,
  output rlit_pkg::cmd_t cmd
);

  import rlit_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = sts.oob ? S_DONE : S_REC;
        end
      end
      S_REC: begin
        cmd.rec_load = 1'b1;
        state_next   = (sts.op == OP_MARK || sts.op == OP_SPAN) ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        cmd.load_step = 1'b1;
        if (sts.load_done) begin
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        if (sts.op == OP_ADD && !sts.refuse) begin
          state_next = S_ABSORB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ABSORB: begin
        cmd.absorb = 1'b1;
        if (!sts.absorb_more) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_step = 1'b1;
        if (sts.write_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/rlit_dp.sv -----
// Datapath: span records, interval store, working list buffer, result and
// output registers, register count. Depends on rlit_pkg, rlit_ifs, rlit_ram.
`timescale 1ns / 1ps

module rlit_dp (
  input  logic           clk,
  input  logic           rst,
  rlit_item_if.sink      item,
  rlit_result_if.source  result,
  rlit_cfg_if.sink       cfg,
  input  rlit_pkg::cmd_t cmd,
  output rlit_pkg::sts_t sts
);

  import rlit_pkg::*;

  localparam pos_t NONE = '1;

  logic [RC_W-1:0]   reg_count;
  logic [NUM_REGS-1:0] rec_valid;

  op_t               op;
  logic [REG_W-1:0]  idx;
  pos_t              pos;
  pos_t              stp;

  pos_t              spn_s;
  pos_t              spn_e;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] k;
  iv_t               buf_q [MAX_INTERVALS];

  logic [1:0]        res_status;
  pos_t              res_start;
  pos_t              res_stop;

  logic              out_valid;
  logic [1:0]        out_status;
  pos_t              out_start;
  pos_t              out_stop;

  logic                         rec_we;
  rec_t                         rec_wdata;
  logic [REC_W-1:0]             rec_rdata;
  rec_t                         rec_cur;
  logic                         iv_we;
  logic                         iv_re;
  logic [$clog2(IV_DEPTH)-1:0]  iv_waddr;
  logic [$clog2(IV_DEPTH)-1:0]  iv_raddr;
  logic [IV_W-1:0]              iv_rdata;

  logic [RC_W-1:0]   bound;
  logic [RC_W-1:0]   new_bound;
  logic [RC_W-1:0]   clr_lo;

  logic              found;
  logic [SLOT_W-1:0] f;
  logic              hit;
  logic [SLOT_W-1:0] k_ins;
  iv_t               buf_ins [MAX_INTERVALS];
  iv_t               buf_hit [MAX_INTERVALS];
  logic [SLOT_W-1:0] kp1;
  logic              more;
  iv_t               buf_abs [MAX_INTERVALS];
  pos_t              mark_s;
  pos_t              mark_e;
  pos_t              stp_raised;

  rlit_ram #(.WIDTH(REC_W), .DEPTH(NUM_REGS)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (idx),
    .wdata (rec_wdata),
    .re    (cmd.capture),
    .raddr (item.reg_index),
    .rdata (rec_rdata)
  );

  rlit_ram #(.WIDTH(IV_W), .DEPTH(IV_DEPTH)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (iv_waddr),
    .wdata (buf_q[cnt[SLOT_W-1:0]]),
    .re    (iv_re),
    .raddr (iv_raddr),
    .rdata (iv_rdata)
  );

  // Bounds and resize range
  assign bound     = (reg_count > RC_W'(NUM_REGS)) ? RC_W'(NUM_REGS) : reg_count;
  assign new_bound = (cfg.register_count > RC_W'(NUM_REGS)) ? RC_W'(NUM_REGS)
                                                            : cfg.register_count;
  assign clr_lo    = (bound < new_bound) ? bound : new_bound;
  assign cfg.ready = 1'b1;

  assign rec_cur = rec_valid[idx] ? rec_t'(rec_rdata) : '{start: NONE, stop: NONE, count: '0};

  // Mark
  always_comb begin
    if (rec_cur.start != NONE) begin
      mark_s = (pos < rec_cur.start) ? pos : rec_cur.start;
      mark_e = (pos > rec_cur.stop) ? pos : rec_cur.stop;
    end else begin
      mark_s = pos;
      mark_e = pos;
    end
  end

  assign rec_we = (cmd.rec_load && op == OP_MARK) || (cmd.wr_step && sts.write_last);

  always_comb begin
    if (cmd.rec_load) begin
      rec_wdata = '{start: mark_s, stop: mark_e, count: rec_cur.count};
    end else begin
      rec_wdata = '{start: spn_s, stop: spn_e, count: n};
    end
  end

  assign iv_re    = cmd.load_step && (cnt < n);
  assign iv_raddr = {idx, cnt[SLOT_W-1:0]};
  assign iv_we    = cmd.wr_step;
  assign iv_waddr = {idx, cnt[SLOT_W-1:0]};

  // Floor search and insert
  always_comb begin
    found = 1'b0;
    f     = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      if (CNT_W'(i) < n && buf_q[i].start <= pos) begin
        found = 1'b1;
        f     = SLOT_W'(i);
      end
    end
    hit   = found && (pos <= buf_q[f].stop);
    k_ins = found ? SLOT_W'(f + 1'b1) : '0;
    buf_hit = buf_q;
    if (stp > buf_q[f].stop) begin
      buf_hit[f].stop = stp;
    end
    buf_ins = buf_q;
    for (int j = 1; j < MAX_INTERVALS; j++) begin
      if (CNT_W'(j) > {1'b0, k_ins} && CNT_W'(j) <= n) begin
        buf_ins[j] = buf_q[j-1];
      end
    end
    buf_ins[k_ins] = '{start: pos, stop: stp};
  end

  // Absorb
  always_comb begin
    kp1  = SLOT_W'(k + 1'b1);
    more = (({1'b0, k} + 1'b1) < n) && (buf_q[kp1].start > buf_q[k].start)
           && (buf_q[kp1].start <= buf_q[k].stop);
    buf_abs = buf_q;
    if (buf_q[kp1].stop > buf_q[k].stop) begin
      buf_abs[k].stop = buf_q[kp1].stop;
    end
    for (int j = 0; j < MAX_INTERVALS - 1; j++) begin
      if (CNT_W'(j) > {1'b0, k}) begin
        buf_abs[j] = buf_q[j+1];
      end
    end
  end

  assign stp_raised = (item.interval_stop < item.position) ? item.position : item.interval_stop;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= op_t'(item.opcode);
      idx        <= item.reg_index;
      pos        <= item.position;
      stp        <= stp_raised;
      res_status <= ({1'b0, item.reg_index} >= bound) ? ST_OOB : ST_OK;
      res_start  <= '0;
      res_stop   <= '0;
    end
    if (cmd.rec_load) begin
      spn_s <= rec_cur.start;
      spn_e <= rec_cur.stop;
      n     <= rec_cur.count;
      cnt   <= '0;
      if (op == OP_SPAN) begin
        res_start <= rec_cur.start;
        res_stop  <= rec_cur.stop;
      end
    end
    if (cmd.load_step) begin
      if (cnt != '0) begin
        buf_q[cnt[SLOT_W-1:0] - 1'b1] <= iv_t'(iv_rdata);
      end
      if (cnt < n) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (cmd.find) begin
      if (op == OP_ACTIVE) begin
        if (n == '0) begin
          res_start <= spn_s;
          res_stop  <= spn_e;
        end else if (hit) begin
          res_start <= (buf_q[f].start > spn_s) ? buf_q[f].start : spn_s;
          res_stop  <= (buf_q[f].stop < spn_e) ? buf_q[f].stop : spn_e;
        end else begin
          res_start <= NONE;
          res_stop  <= NONE;
        end
      end else if (hit) begin
        buf_q <= buf_hit;
        k     <= f;
      end else if (sts.refuse) begin
        res_status <= ST_FULL;
      end else begin
        buf_q <= buf_ins;
        k     <= k_ins;
        n     <= n + 1'b1;
      end
    end
    if (cmd.absorb) begin
      if (more) begin
        buf_q <= buf_abs;
        n     <= n - 1'b1;
      end else begin
        cnt <= '0;
      end
    end
    if (cmd.wr_step) begin
      cnt <= cnt + 1'b1;
    end
    if (cmd.emit) begin
      out_status <= res_status;
      out_start  <= res_start;
      out_stop   <= res_stop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_count <= '0;
      rec_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (rec_we) begin
        rec_valid[idx] <= 1'b1;
      end
      if (cfg.valid) begin
        reg_count <= cfg.register_count;
        for (int r = 0; r < NUM_REGS; r++) begin
          if (RC_W'(r) >= clr_lo) begin
            rec_valid[r] <= 1'b0;
          end
        end
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.out_start = out_start;
  assign result.out_stop  = out_stop;

  assign sts.oob         = ({1'b0, item.reg_index} >= bound);
  assign sts.op          = op;
  assign sts.load_done   = (cnt == n);
  assign sts.refuse      = (op == OP_ADD) && !hit && (n == CNT_W'(MAX_INTERVALS));
  assign sts.absorb_more = more;
  assign sts.write_last  = (cnt == n - 1'b1);
  assign sts.out_free    = !out_valid || result.ready;

endmodule

// ----- rtl/core/register_lifetime_interval_table.sv -----
// Register lifetime interval table, top level.
// Sequence: mark and span read the record and hand off the result; add and
// active then load the stored intervals and search them, and add goes on to
// absorb overlapping entries and write the list back, all paced by the
// interval store (one entry per cycle). Items: one at a time, taken after the last is handed off.
// Reset: synchronous, clears register count, record valid bits and output valid.
`timescale 1ns / 1ps

module register_lifetime_interval_table (
  input  logic          clk,
  input  logic          rst,
  rlit_item_if.sink     item,
  rlit_result_if.source result,
  rlit_cfg_if.sink      cfg
);

  import rlit_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic item_ready;

  assign item.ready = item_ready;

  rlit_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rlit_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ----- tb/tb_register_lifetime_interval_table.sv -----
// Self-checking testbench for the register lifetime interval table.
// Drives item, result and configuration channels; depends on rlit_pkg and rlit_ifs.
`timescale 1ns / 1ps

module tb_register_lifetime_interval_table;
  import rlit_pkg::*;

  localparam pos_t NONE = '1;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [1:0] status;
    pos_t       start;
    pos_t       stop;
  } res_t;

  typedef struct {
    op_t           op;
    logic [7:0]    idx;
    pos_t          pos;
    pos_t          stp;
    bit            typed;
    res_t          want;
  } row_t;

  logic clk;
  logic rst;
  rlit_item_if   item();
  rlit_result_if result();
  rlit_cfg_if    cfg();

  register_lifetime_interval_table dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  // predictor state
  int   live_count;
  pos_t span_lo [NUM_REGS];
  pos_t span_hi [NUM_REGS];
  pos_t ivs [NUM_REGS][MAX_INTERVALS];
  pos_t ive [NUM_REGS][MAX_INTERVALS];
  int   ivn [NUM_REGS];

  res_t pending[$];
  int   errors;
  int   idle_cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int bounded(int c);
    return c < NUM_REGS ? c : NUM_REGS;
  endfunction

  function automatic void wipe_reg(int r);
    span_lo[r] = NONE;
    span_hi[r] = NONE;
    ivn[r] = 0;
  endfunction

  function automatic void resize_table(int value);
    int lo;
    lo = bounded(live_count) < bounded(value) ? bounded(live_count) : bounded(value);
    live_count = value;
    for (int r = lo; r < NUM_REGS; r++) wipe_reg(r);
  endfunction

  function automatic int floor_slot(int r, pos_t p);
    int f;
    f = -1;
    for (int i = 0; i < ivn[r]; i++) if (ivs[r][i] <= p) f = i;
    return f;
  endfunction

  function automatic res_t apply_item(op_t op, logic [7:0] idx, pos_t p, pos_t s);
    res_t o;
    int   r, f, k, n;
    o = '0;
    r = idx;
    if (r >= bounded(live_count)) begin
      o.status = ST_OOB;
      return o;
    end
    case (op)
      OP_MARK: begin
        if (span_lo[r] != NONE) begin
          if (p < span_lo[r]) span_lo[r] = p;
          if (p > span_hi[r]) span_hi[r] = p;
        end else begin
          span_lo[r] = p;
          span_hi[r] = p;
        end
      end
      OP_ADD: begin
        n = ivn[r];
        if (s < p) s = p;
        f = floor_slot(r, p);
        if (f >= 0 && p <= ive[r][f]) begin
          k = f;
          if (s > ive[r][k]) ive[r][k] = s;
        end else if (n >= MAX_INTERVALS) begin
          o.status = ST_FULL;
          return o;
        end else begin
          k = f + 1;
          for (int i = n; i > k; i--) begin
            ivs[r][i] = ivs[r][i-1];
            ive[r][i] = ive[r][i-1];
          end
          ivs[r][k] = p;
          ive[r][k] = s;
          n++;
        end
        while (k + 1 < n && ivs[r][k+1] > ivs[r][k] && ivs[r][k+1] <= ive[r][k]) begin
          if (ive[r][k+1] > ive[r][k]) ive[r][k] = ive[r][k+1];
          for (int i = k + 1; i < n - 1; i++) begin
            ivs[r][i] = ivs[r][i+1];
            ive[r][i] = ive[r][i+1];
          end
          n--;
        end
        ivn[r] = n;
      end
      OP_SPAN: begin
        o.start = span_lo[r];
        o.stop  = span_hi[r];
      end
      default: begin
        o.start = span_lo[r];
        o.stop  = span_hi[r];
        if (ivn[r] != 0) begin
          f = floor_slot(r, p);
          if (f >= 0 && p >= ivs[r][f] && p <= ive[r][f]) begin
            if (ivs[r][f] > o.start) o.start = ivs[r][f];
            if (ive[r][f] < o.stop) o.stop = ive[r][f];
          end else begin
            o.start = NONE;
            o.stop  = NONE;
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic report(string what, res_t got, res_t want);
    $display("mismatch %s: got %0d %h %h want %0d %h %h", what,
             got.status, got.start, got.stop, want.status, want.start, want.stop);
    errors++;
  endtask

  task automatic gap(int slow);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (slow == 0) n = 0;
    if (n != 0) begin
      item.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_item(op_t op, logic [7:0] idx, pos_t p, pos_t s, int slow);
    gap(slow);
    item.valid         <= 1'b1;
    item.opcode        <= op;
    item.reg_index     <= idx;
    item.position      <= p;
    item.interval_stop <= s;
    do @(posedge clk); while (!item.ready);
    pending.push_back(apply_item(op, idx, p, s));
    @(negedge clk);
  endtask

  task automatic write_count(int value);
    item.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg.valid          <= 1'b1;
    cfg.register_count <= value[8:0];
    do @(posedge clk); while (!cfg.ready);
    resize_table(value);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  function automatic pos_t rand_pos(logic [7:0] r);
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFE : 32'd0;
      1: return $urandom();
      default: return 32'(r) * 1000 + $urandom_range(0, 400);
    endcase
  endfunction

  // result side: random stalls, compare against the oldest prediction
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 60) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(5, 30)) @(negedge clk);
        result.ready <= 1'b1;
      end else begin
        result.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    res_t got, want;
    if (!rst && result.valid && result.ready) begin
      got = '{result.status, result.out_start, result.out_stop};
      if (pending.size() == 0) begin
        report("unexpected word", got, '0);
      end else begin
        want = pending.pop_front();
        if (got.status != want.status) report("status", got, want);
        if (got.start != want.start) report("out_start", got, want);
        if (got.stop != want.stop) report("out_stop", got, want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    row_t tbl[$];
    row_t rw;
    op_t  op;
    logic [7:0] r;
    pos_t p;
    int   counts[6];
    errors = 0;
    live_count = 0;
    for (int i = 0; i < NUM_REGS; i++) wipe_reg(i);
    rst = 1'b1;
    item.valid = 1'b0;
    item.opcode = OP_MARK;
    item.reg_index = '0;
    item.position = '0;
    item.interval_stop = '0;
    cfg.valid = 1'b0;
    cfg.register_count = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // out of bounds right after reset
    send_item(OP_SPAN, 8'd0, '0, '0, 0);
    write_count(4);
    tbl = '{
      '{OP_SPAN,   8'd0,   32'd0,         32'd0,         1, '{ST_OK, NONE, NONE}},
      '{OP_ACTIVE, 8'd1,   32'd5,         32'd0,         1, '{ST_OK, NONE, NONE}},
      '{OP_MARK,   8'd4,   32'd1,         32'd1,         1, '{ST_OOB, 32'd0, 32'd0}},
      '{OP_MARK,   8'd255, 32'd1,         32'd1,         1, '{ST_OOB, 32'd0, 32'd0}},
      '{OP_MARK,   8'd0,   32'd100,       32'd0,         1, '{ST_OK, 32'd0, 32'd0}},
      '{OP_MARK,   8'd0,   32'd0,         32'd0,         0, '0},
      '{OP_MARK,   8'd0,   32'hFFFF_FFFE, 32'd0,         0, '0},
      '{OP_SPAN,   8'd0,   32'd0,         32'd0,         1, '{ST_OK, 32'd0, 32'hFFFF_FFFE}},
      '{OP_MARK,   8'd1,   32'hFFFF_FFFF, 32'd0,         0, '0},
      '{OP_SPAN,   8'd1,   32'd0,         32'd0,         0, '0},
      '{OP_ADD,    8'd1,   32'd50,        32'd10,        0, '0},
      '{OP_ACTIVE, 8'd1,   32'd50,        32'd0,         0, '0},
      '{OP_ADD,    8'd0,   32'd10,        32'd20,        1, '{ST_OK, 32'd0, 32'd0}},
      '{OP_ADD,    8'd0,   32'd30,        32'd40,        0, '0},
      '{OP_ADD,    8'd0,   32'd15,        32'd35,        0, '0},
      '{OP_ACTIVE, 8'd0,   32'd33,        32'd0,         0, '0},
      '{OP_ACTIVE, 8'd0,   32'd45,        32'd0,         0, '0},
      '{OP_ACTIVE, 8'd0,   32'd0,         32'd0,         0, '0},
      '{OP_ADD,    8'd0,   32'd0,         32'hFFFF_FFFE, 0, '0},
      '{OP_ACTIVE, 8'd0,   32'hFFFF_FFFE, 32'd0,         0, '0}
    };
    foreach (tbl[i]) begin
      rw = tbl[i];
      send_item(rw.op, rw.idx, rw.pos, rw.stp, 0);
      if (rw.typed) pending[$] = rw.want;
    end
    // fill one list to the limit, then refuse
    for (int i = 0; i <= MAX_INTERVALS; i++)
      send_item(OP_ADD, 8'd2, 32'(i * 10), 32'(i * 10 + 2), 0);
    send_item(OP_ADD, 8'd2, 32'd4, 32'd5, 0);
    send_item(OP_ACTIVE, 8'd2, 32'd31, 32'd0, 0);

    // random phases over several counts, extremes included
    counts = '{256, 9, 1, 300, 0, 37};
    foreach (counts[ph]) begin
      write_count(counts[ph] == 300 ? 511 : counts[ph]);
      for (int n = 0; n < 240; n++) begin
        op = op_t'($urandom_range(0, 3));
        r  = (live_count > 0 && $urandom_range(0, 9) != 0) ?
             8'($urandom_range(0, bounded(live_count) - 1) % 8) : 8'($urandom());
        if ($urandom_range(0, 3) == 0 && live_count > 0)
          r = 8'($urandom_range(0, bounded(live_count) - 1));
        p = rand_pos(r);
        send_item(op, r, p,
                  ($urandom_range(0, 7) == 0) ? $urandom() : p + $urandom_range(0, 300),
                  $urandom_range(0, 4) != 0);
      end
    end
    item.valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
